### rtl/rgbq_pkg.sv
// Shared types and constants for the RGBA to palette quantizer.
// No dependencies; used by every RTL module of the block.
package rgbq_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pixel;

    typedef struct packed {
        logic [5:0] palette_code;
        logic       keep_existing;
    } t_result;

    // palette codes
    localparam logic [5:0] PAL_BLACK  = 6'h00;
    localparam logic [5:0] PAL_BLUE   = 6'h01;
    localparam logic [5:0] PAL_GREEN  = 6'h02;
    localparam logic [5:0] PAL_PURPLE = 6'h05;
    localparam logic [5:0] PAL_LGRAY  = 6'h07;
    localparam logic [5:0] PAL_DGRAY  = 6'h08;
    localparam logic [5:0] PAL_LBLUE  = 6'h09;
    localparam logic [5:0] PAL_LCYAN  = 6'h0B;
    localparam logic [5:0] PAL_ORANGE = 6'h0C;
    localparam logic [5:0] PAL_LMAG   = 6'h0D;
    localparam logic [5:0] PAL_YELLOW = 6'h0E;
    localparam logic [5:0] PAL_SILVER = 6'h38;
    localparam logic [5:0] PAL_WHITE  = 6'h3F;

    localparam logic [7:0] NEAR_WHITE_MIN = 8'd250;
    localparam logic [8:0] GRAY_GAP_LIMIT = 9'd30;

    // channel*5/255 is floor(channel/51): level above 3 is >= 204, below 2 is < 102
    localparam logic [7:0] LEVEL_HIGH_MIN = 8'd204;
    localparam logic [7:0] LEVEL_LOW_LIM  = 8'd102;

    // gray bands on sum/3, rewritten as bounds on the sum
    localparam logic [9:0] GRAY_SUM_B0 = 10'd96;
    localparam logic [9:0] GRAY_SUM_B1 = 10'd288;
    localparam logic [9:0] GRAY_SUM_B2 = 10'd480;
    localparam logic [9:0] GRAY_SUM_B3 = 10'd672;

    localparam logic [9:0] BRIGHT_SUM_B0 = 10'd128;
    localparam logic [9:0] BRIGHT_SUM_B1 = 10'd384;

endpackage

### rtl/rgbq_classify.sv
// Priority rules that map one pixel to a palette code, purely combinational.
// Depends on rgbq_pkg.
module rgbq_classify
    import rgbq_pkg::*;
(
    input  t_pixel  i_pixel,
    output t_result o_result
);

    logic [7:0] r, g, b;
    logic [9:0] sum;
    logic [8:0] gap_rg, gap_rb;
    logic       r_hi, g_hi, b_hi, r_lo, g_lo, b_lo;
    logic [5:0] code;

    assign r = i_pixel.red;
    assign g = i_pixel.green;
    assign b = i_pixel.blue;

    assign sum    = {2'b00, r} + {2'b00, g} + {2'b00, b};
    assign gap_rg = (r > g) ? {1'b0, r - g} : {1'b0, g - r};
    assign gap_rb = (r > b) ? {1'b0, r - b} : {1'b0, b - r};

    assign r_hi = (r >= LEVEL_HIGH_MIN);
    assign g_hi = (g >= LEVEL_HIGH_MIN);
    assign b_hi = (b >= LEVEL_HIGH_MIN);
    assign r_lo = (r < LEVEL_LOW_LIM);
    assign g_lo = (g < LEVEL_LOW_LIM);
    assign b_lo = (b < LEVEL_LOW_LIM);

    always_comb begin
        priority if (sum == 10'd0) begin
            code = PAL_BLACK;
        end else if (r >= NEAR_WHITE_MIN && g >= NEAR_WHITE_MIN && b >= NEAR_WHITE_MIN) begin
            code = PAL_WHITE;
        end else if (r > 8'd200 && g < 8'd120 && b < 8'd60) begin
            code = PAL_ORANGE;
        end else if (r > 8'd100 && r < 8'd150 && g < 8'd60 && b > 8'd60) begin
            code = PAL_PURPLE;
        end else if (gap_rg < GRAY_GAP_LIMIT && gap_rb < GRAY_GAP_LIMIT) begin
            priority if (sum < GRAY_SUM_B0) begin
                code = PAL_BLACK;
            end else if (sum < GRAY_SUM_B1) begin
                code = PAL_DGRAY;
            end else if (sum < GRAY_SUM_B2) begin
                code = PAL_LGRAY;
            end else if (sum < GRAY_SUM_B3) begin
                code = PAL_SILVER;
            end else begin
                code = PAL_WHITE;
            end
        end else if (r_hi && g_lo && b_lo) begin
            code = PAL_ORANGE;
        end else if (g_hi && r_lo && b_lo) begin
            code = PAL_GREEN;
        end else if (b_hi && r_lo && g_lo) begin
            code = PAL_LBLUE;
        end else if (r_hi && g_hi && b_lo) begin
            code = PAL_YELLOW;
        end else if (r_hi && b_hi && g_lo) begin
            code = PAL_LMAG;
        end else if (g_hi && b_hi && r_lo) begin
            code = PAL_LCYAN;
        end else if (sum < BRIGHT_SUM_B0) begin
            code = PAL_DGRAY;
        end else if (sum < BRIGHT_SUM_B1) begin
            code = PAL_LGRAY;
        end else begin
            code = PAL_SILVER;
        end
    end

    // alpha below 128: destination kept, code forced to zero
    always_comb begin
        if (!i_pixel.alpha[7]) begin
            o_result.palette_code  = PAL_BLACK;
            o_result.keep_existing = 1'b1;
        end else begin
            o_result.palette_code  = code;
            o_result.keep_existing = 1'b0;
        end
    end

endmodule

### rtl/rgba_to_palette_quantizer.sv
// RGBA pixel to 6-bit palette code: input register, classifier, result register.
// An accepted request is held in the input register, its result in the result register.
// Takes one request per cycle unless stalled; single-pass classifier between registers.
// Synchronous active-low reset clears both valid flags; pixel and result are not reset.
// Depends on rgbq_pkg and rgbq_classify.
module rgba_to_palette_quantizer
    import rgbq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_pixel  i_pixel,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result
);

    logic    r_s1_valid;
    t_pixel  r_s1_pixel;
    logic    r_out_valid;
    t_result r_out_result;
    t_result s1_result;
    logic    s2_ready;
    logic    s1_ready;

    assign s2_ready   = !r_out_valid || i_out_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_in_ready = s1_ready;

    rgbq_classify u_classify (
        .i_pixel  (r_s1_pixel),
        .o_result (s1_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_s1_pixel <= i_pixel;
        end
        if (s2_ready && r_s1_valid) begin
            r_out_result <= s1_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out_result;

endmodule

### rtl/rgbq_checker.sv
// Port-level checks for rgba_to_palette_quantizer, bound to the top level.
// Depends on rgbq_pkg.
module rgbq_checker
    import rgbq_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    o_in_ready,
    input t_pixel  i_pixel,
    input logic    o_out_valid,
    input logic    i_out_ready,
    input t_result o_result
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result))
        else $error("stalled result changed");

    a_keep_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result.keep_existing |-> o_result.palette_code == PAL_BLACK)
        else $error("transparent result with nonzero code");

    // input side only backs up when both stages hold requests
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without full pipeline");

endmodule

bind rgba_to_palette_quantizer rgbq_checker u_rgbq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_pixel     (i_pixel),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_result    (o_result)
);

### tb/rgba_to_palette_quantizer_tb.sv
// Testbench for rgba_to_palette_quantizer: directed and random pixel requests
// checked field by field against an in-bench palette predictor.
// Depends on rgbq_pkg for the pixel/result structs and the palette codes.
module rgba_to_palette_quantizer_tb
    import rgbq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_CAP    = 40;

    // channel values that sit on or next to the classifier's thresholds
    localparam logic [7:0] CHANNEL_MARKS [0:15] = '{
        8'd0, 8'd30, 8'd32, 8'd60, 8'd96, 8'd100, 8'd102, 8'd120,
        8'd128, 8'd150, 8'd160, 8'd200, 8'd204, 8'd224, 8'd250, 8'd255
    };

    typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_in_valid;
    logic    o_in_ready;
    t_pixel  i_pixel;
    logic    o_out_valid;
    logic    i_out_ready;
    t_result o_result;

    t_result  expected_codes[$];
    t_result  oldest_code;
    int       mismatch_count = 0;
    int       cycle_count = 0;
    int       hold_off_cycles = 0;
    int       rx_tick = 0;
    t_rx_mode rx_mode = RX_STREAM;

    rgba_to_palette_quantizer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_pixel    (i_pixel),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_result   (o_result)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Expected palette result for one pixel, priority rules top to bottom.
    function automatic t_result predict_palette(input t_pixel px);
        t_result     res;
        int unsigned r, g, b, total, gap_rg, gap_rb, mean, lr, lg, lb;
        r = px.red;
        g = px.green;
        b = px.blue;
        total = r + g + b;
        res.keep_existing = 1'b0;
        res.palette_code  = PAL_BLACK;
        if (px.alpha < 8'd128) begin
            res.keep_existing = 1'b1;
            return res;
        end
        if (r == 0 && g == 0 && b == 0) begin
            res.palette_code = PAL_BLACK;
            return res;
        end
        if (r >= 250 && g >= 250 && b >= 250) begin
            res.palette_code = PAL_WHITE;
            return res;
        end
        if (r > 200 && g < 120 && b < 60) begin
            res.palette_code = PAL_ORANGE;
            return res;
        end
        if (r > 100 && r < 150 && g < 60 && b > 60) begin
            res.palette_code = PAL_PURPLE;
            return res;
        end
        gap_rg = (r > g) ? r - g : g - r;
        gap_rb = (r > b) ? r - b : b - r;
        if (gap_rg < 30 && gap_rb < 30) begin
            mean = total / 3;
            if (mean < 32)       res.palette_code = PAL_BLACK;
            else if (mean < 96)  res.palette_code = PAL_DGRAY;
            else if (mean < 160) res.palette_code = PAL_LGRAY;
            else if (mean < 224) res.palette_code = PAL_SILVER;
            else                 res.palette_code = PAL_WHITE;
            return res;
        end
        lr = (r * 5) / 255;
        lg = (g * 5) / 255;
        lb = (b * 5) / 255;
        if (lr > 3 && lg < 2 && lb < 2)      res.palette_code = PAL_ORANGE;
        else if (lg > 3 && lr < 2 && lb < 2) res.palette_code = PAL_GREEN;
        else if (lb > 3 && lr < 2 && lg < 2) res.palette_code = PAL_LBLUE;
        else if (lr > 3 && lg > 3 && lb < 2) res.palette_code = PAL_YELLOW;
        else if (lr > 3 && lb > 3 && lg < 2) res.palette_code = PAL_LMAG;
        else if (lg > 3 && lb > 3 && lr < 2) res.palette_code = PAL_LCYAN;
        else if (total < 128)                res.palette_code = PAL_DGRAY;
        else if (total < 384)                res.palette_code = PAL_LGRAY;
        else                                 res.palette_code = PAL_SILVER;
        return res;
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel      px;
        int unsigned pick;
        logic [7:0]  base;
        pick = $urandom_range(0, 9);
        base = 8'($urandom);
        if (pick < 3) begin
            px.red   = 8'($urandom);
            px.green = 8'($urandom);
            px.blue  = 8'($urandom);
        end else if (pick < 6) begin
            // near-gray: exercises the gap limit and the mean bands
            px.red   = base;
            px.green = 8'(base + $urandom_range(0, 70) - 35);
            px.blue  = 8'(base + $urandom_range(0, 70) - 35);
        end else if (pick < 9) begin
            px.red   = 8'(CHANNEL_MARKS[$urandom_range(0, 15)] + $urandom_range(0, 4) - 2);
            px.green = 8'(CHANNEL_MARKS[$urandom_range(0, 15)] + $urandom_range(0, 4) - 2);
            px.blue  = 8'(CHANNEL_MARKS[$urandom_range(0, 15)] + $urandom_range(0, 4) - 2);
        end else begin
            // saturated mixes of low and high levels
            px.red   = $urandom_range(0, 1) ? 8'($urandom_range(204, 255))
                                            : 8'($urandom_range(0, 101));
            px.green = $urandom_range(0, 1) ? 8'($urandom_range(204, 255))
                                            : 8'($urandom_range(0, 101));
            px.blue  = $urandom_range(0, 1) ? 8'($urandom_range(204, 255))
                                            : 8'($urandom_range(0, 101));
        end
        px.alpha = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 127))
                                                : 8'($urandom_range(128, 255));
        return px;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Holds valid high with a fixed payload until the request is taken.
    task automatic send_pixel(input logic [7:0] r, g, b, a);
        i_in_valid <= 1'b1;
        i_pixel    <= '{red: r, green: g, blue: b, alpha: a};
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
    endtask

    task automatic pause_sender(input int cycles);
        i_in_valid <= 1'b0;
        i_pixel    <= t_pixel'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic send_random(input int count, input int max_gap);
        t_pixel px;
        int     burst;
        while (count > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && count > 0) begin
                px = random_pixel();
                send_pixel(px.red, px.green, px.blue, px.alpha);
                burst--;
                count--;
            end
            if (max_gap > 0 && $urandom_range(0, 3) != 0) begin
                pause_sender($urandom_range(1, max_gap));
            end
        end
    endtask

    task automatic test_transparency();
        send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd0,   8'd127);
        send_pixel(8'd255, 8'd0,   8'd255, 8'd128);
        send_pixel(8'd60,  8'd60,  8'd60,  8'd255);
    endtask

    task automatic test_fixed_colors();
        send_pixel(8'd0,   8'd0,   8'd0,   8'd255);   // exact black
        send_pixel(8'd250, 8'd250, 8'd250, 8'd200);   // near white, lower edge
        send_pixel(8'd249, 8'd250, 8'd250, 8'd255);   // just misses near white
        send_pixel(8'd201, 8'd119, 8'd59,  8'd255);   // orange
        send_pixel(8'd200, 8'd119, 8'd59,  8'd255);   // red one short of orange
        send_pixel(8'd101, 8'd59,  8'd61,  8'd255);   // purple
    endtask

    task automatic test_gray_bands();
        send_pixel(8'd31,  8'd31,  8'd31,  8'd255);
        send_pixel(8'd32,  8'd33,  8'd31,  8'd255);
        send_pixel(8'd95,  8'd95,  8'd95,  8'd255);
        send_pixel(8'd96,  8'd96,  8'd96,  8'd255);
        send_pixel(8'd160, 8'd140, 8'd180, 8'd255);
        send_pixel(8'd224, 8'd224, 8'd224, 8'd255);
    endtask

    task automatic test_hues();
        send_pixel(8'd204, 8'd101, 8'd101, 8'd255);
        send_pixel(8'd0,   8'd255, 8'd0,   8'd255);
        send_pixel(8'd0,   8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0,   8'd255);
        send_pixel(8'd255, 8'd0,   8'd255, 8'd255);
        send_pixel(8'd0,   8'd255, 8'd255, 8'd255);
    endtask

    task automatic test_brightness_bands();
        send_pixel(8'd100, 8'd0,   8'd20,  8'd255);
        send_pixel(8'd200, 8'd100, 8'd0,   8'd255);
        send_pixel(8'd150, 8'd200, 8'd100, 8'd255);
    endtask

    task automatic test_random_stream();
        send_random(500, 6);
        pause_sender(1);
    endtask

    // Receiver holds off while requests keep coming, so the input stalls.
    task automatic test_back_pressure();
        hold_off_cycles = 80;
        send_random(40, 0);
        pause_sender(1);
    endtask

    task automatic test_back_to_back();
        send_random(110, 0);
        pause_sender(1);
    endtask

    // receiver: own stall pattern, plus long hold-offs on request
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles != 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
            end else begin
                rx_tick++;
                if (rx_tick % 97 == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 3));
                end
                case (rx_mode)
                    RX_STREAM:   i_out_ready <= 1'b1;
                    RX_COIN:     i_out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   i_out_ready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: i_out_ready <= ((rx_tick % 5) < 3);
                    default:     i_out_ready <= 1'b1;
                endcase
            end
        end
    end

    // request tracking and result checking
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready === 1'b1) begin
                expected_codes.push_back(predict_palette(i_pixel));
            end
            if ($isunknown(o_out_valid)) begin
                report_mismatch("o_out_valid is unknown");
            end else if (o_out_valid && i_out_ready) begin
                if (expected_codes.size() == 0) begin
                    report_mismatch("result with no request pending");
                end else begin
                    oldest_code = expected_codes.pop_front();
                    if (o_result.palette_code !== oldest_code.palette_code) begin
                        report_mismatch($sformatf("palette_code got %h want %h",
                            o_result.palette_code, oldest_code.palette_code));
                    end
                    if (o_result.keep_existing !== oldest_code.keep_existing) begin
                        report_mismatch($sformatf("keep_existing got %b want %b",
                            o_result.keep_existing, oldest_code.keep_existing));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("rgba_to_palette_quantizer_tb: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_pixel    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_transparency();
        test_fixed_colors();
        test_gray_bands();
        test_hues();
        test_brightness_bands();
        pause_sender(2);
        test_random_stream();
        test_back_pressure();
        test_back_to_back();

        while (expected_codes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_codes.size() == 0) begin
            $display("rgba_to_palette_quantizer_tb: PASS");
        end else begin
            $display("rgba_to_palette_quantizer_tb: FAIL");
        end
        $finish;
    end

endmodule

### rgba_to_palette_quantizer.f
rtl/rgbq_pkg.sv
rtl/rgbq_classify.sv
rtl/rgba_to_palette_quantizer.sv
rtl/rgbq_checker.sv
tb/rgba_to_palette_quantizer_tb.sv
